FILE: rtl/core/prra_pkg.sv
// shared types and constants for the page rounded region allocator
package prra_pkg;

    localparam int SLOT_COUNT = 32;
    localparam int PAGE_SHIFT = 12;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);

    localparam logic [31:0] PAGE_BYTES = 32'(64'd1 << PAGE_SHIFT);
    localparam logic [31:0] PAGE_MASK  = PAGE_BYTES - 32'd1;
    localparam logic [31:0] SIZE_LIMIT = 32'hFFFF_FFFF - PAGE_BYTES;

    localparam logic [31:0] BASE_RESET = 32'h4000_0000;
    localparam logic [31:0] TOP_RESET  = 32'h8000_0000;

    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEAP_BASE = 1'b0,
        REG_HEAP_TOP  = 1'b1
    } cfg_idx_e;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_FREE    = 2'd1,
        CMD_REALLOC = 2'd2
    } cmd_e;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_COMMIT_A,
        ST_COMMIT_B,
        ST_DONE
    } eng_state_t;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] span;
        logic [31:0] asked;
    } slot_entry_t;

    typedef struct packed {
        logic        status;
        logic [31:0] result_address;
        logic [31:0] copy_bytes;
    } result_t;

endpackage

FILE: rtl/core/prra_slot_mem.sv
// slot table memory with one read and one write port and per-entry written bits
module prra_slot_mem
    import prra_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_idx,
    output slot_entry_t       rd_data,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_idx,
    input  slot_entry_t       wr_data
);

    slot_entry_t             mem [SLOT_COUNT];
    slot_entry_t             q_reg;
    logic [SLOT_COUNT-1:0]   written_reg;
    logic                    q_written_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg <= mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg   <= '0;
            q_written_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_idx] <= 1'b1;
            end
            if (rd_en)
            begin
                q_written_reg <= written_reg[rd_idx];
            end
        end
    end

    // an entry never written reads as the cleared slot
    assign rd_data = q_written_reg ? q_reg : '0;

endmodule

FILE: rtl/core/prra_engine.sv
// command sequencer: slot table scan, decision and write-back
module prra_engine
    import prra_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [1:0]   start_cmd,
    input  logic [31:0]  start_size,
    input  logic [31:0]  start_addr,
    output logic         idle,
    input  logic [31:0]  heap_base,
    input  logic [31:0]  heap_top,
    output logic         done,
    output result_t      res,
    input  logic         res_take
);

    eng_state_t            state_reg, state_next;

    logic [1:0]            cmd_reg;
    logic [31:0]           size_reg;
    logic [31:0]           addr_reg;
    logic [31:0]           need_reg;
    logic                  size_bad_reg;

    logic [CNT_W-1:0]      iss_cnt_reg;
    logic                  ev_valid_reg;
    logic [IDX_W-1:0]      ev_idx_reg;

    logic                  reuse_found_reg;
    logic [IDX_W-1:0]      reuse_idx_reg;
    logic [31:0]           reuse_start_reg;
    logic [31:0]           reuse_span_reg;
    logic                  fresh_found_reg;
    logic [IDX_W-1:0]      fresh_idx_reg;
    logic                  match_found_reg;
    logic [IDX_W-1:0]      match_idx_reg;
    logic [31:0]           match_span_reg;
    logic [31:0]           match_asked_reg;

    logic [SLOT_COUNT-1:0] taken_reg;
    logic [31:0]           cursor_reg;

    logic                  w1_en_reg;
    logic [IDX_W-1:0]      w1_idx_reg;
    slot_entry_t           w1_entry_reg;
    logic                  bump_reg;
    logic                  w2_en_reg;
    logic [IDX_W-1:0]      w2_idx_reg;
    slot_entry_t           w2_entry_reg;
    result_t               res_reg;

    logic [31:0]           start_need;
    logic                  start_size_bad;

    logic                  rd_en;
    slot_entry_t           rd_data;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_idx;
    slot_entry_t           wr_data;

    logic                  ev_taken;
    logic                  hit_reuse;
    logic                  hit_fresh;
    logic                  hit_match;
    logic                  scan_last;

    logic                  cursor_ok;
    logic                  a_ok;
    logic                  a_bump;
    logic [IDX_W-1:0]      a_idx;
    slot_entry_t           a_entry;
    logic [31:0]           a_addr;

    logic                  d_ok;
    logic [31:0]           d_addr;
    logic [31:0]           d_copy;
    logic                  d_w1_en;
    logic [IDX_W-1:0]      d_w1_idx;
    slot_entry_t           d_w1_entry;
    logic                  d_bump;
    logic                  d_w2_en;

    assign start_need     = (start_size + PAGE_MASK) & ~PAGE_MASK;
    assign start_size_bad = (start_size == 32'd0) || (start_size > SIZE_LIMIT);

    prra_slot_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_idx  (iss_cnt_reg[IDX_W-1:0]),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_data (wr_data)
    );

    // scan: one slot read issued per cycle, evaluated in the cycle after its issue
    assign rd_en     = (state_reg == ST_SCAN) && (iss_cnt_reg < CNT_W'(SLOT_COUNT));
    assign ev_taken  = taken_reg[ev_idx_reg];
    assign hit_reuse = ev_valid_reg && !ev_taken && (rd_data.start != 32'd0)
                       && (rd_data.span >= need_reg);
    assign hit_fresh = ev_valid_reg && !ev_taken && (rd_data.start == 32'd0);
    assign hit_match = ev_valid_reg && ev_taken && (rd_data.start == addr_reg);
    assign scan_last = ev_valid_reg && (ev_idx_reg == IDX_W'(SLOT_COUNT - 1));

    // write-back port: allocation or in-place update first, then release
    always_comb
    begin
        wr_en   = 1'b0;
        wr_idx  = w1_idx_reg;
        wr_data = w1_entry_reg;
        if (state_reg == ST_COMMIT_A)
        begin
            wr_en = w1_en_reg;
        end
        else if (state_reg == ST_COMMIT_B)
        begin
            wr_en   = w2_en_reg;
            wr_idx  = w2_idx_reg;
            wr_data = w2_entry_reg;
        end
    end

    // allocation outcome from the scan results
    always_comb
    begin
        cursor_ok = (cursor_reg >= heap_base) && (cursor_reg < heap_top)
                    && (need_reg <= heap_top - cursor_reg);
        a_ok    = 1'b0;
        a_bump  = 1'b0;
        a_idx   = fresh_idx_reg;
        a_entry = '{start: cursor_reg, span: need_reg, asked: size_reg};
        a_addr  = cursor_reg;
        priority if (size_bad_reg)
        begin
            a_ok = 1'b0;
        end
        else if (reuse_found_reg)
        begin
            a_ok    = 1'b1;
            a_idx   = reuse_idx_reg;
            a_entry = '{start: reuse_start_reg, span: reuse_span_reg, asked: size_reg};
            a_addr  = reuse_start_reg;
        end
        else if (fresh_found_reg && cursor_ok)
        begin
            a_ok   = 1'b1;
            a_bump = 1'b1;
        end
        else
        begin
            a_ok = 1'b0;
        end
    end

    // command decision
    always_comb
    begin
        d_ok       = 1'b0;
        d_addr     = 32'd0;
        d_copy     = 32'd0;
        d_w1_en    = 1'b0;
        d_w1_idx   = a_idx;
        d_w1_entry = a_entry;
        d_bump     = 1'b0;
        d_w2_en    = 1'b0;
        priority if (cmd_reg == CMD_FREE)
        begin
            if (addr_reg == 32'd0)
            begin
                d_ok = 1'b1;
            end
            else if (match_found_reg)
            begin
                d_ok    = 1'b1;
                d_w2_en = 1'b1;
            end
        end
        else if ((cmd_reg == CMD_ALLOC) || ((cmd_reg == CMD_REALLOC) && (addr_reg == 32'd0)))
        begin
            d_ok    = a_ok;
            d_addr  = a_ok ? a_addr : 32'd0;
            d_w1_en = a_ok;
            d_bump  = a_ok && a_bump;
        end
        else if ((cmd_reg == CMD_REALLOC) && (size_reg == 32'd0))
        begin
            d_ok    = 1'b1;
            d_w2_en = match_found_reg;
        end
        else if ((cmd_reg == CMD_REALLOC) && match_found_reg)
        begin
            if (size_reg <= match_span_reg)
            begin
                d_ok       = 1'b1;
                d_addr     = addr_reg;
                d_w1_en    = 1'b1;
                d_w1_idx   = match_idx_reg;
                d_w1_entry = '{start: addr_reg, span: match_span_reg, asked: size_reg};
            end
            else if (a_ok)
            begin
                d_ok    = 1'b1;
                d_addr  = a_addr;
                d_copy  = (match_asked_reg < size_reg) ? match_asked_reg : size_reg;
                d_w1_en = 1'b1;
                d_bump  = a_bump;
                d_w2_en = 1'b1;
            end
        end
        else
        begin
            // unmatched resize or unknown command
            d_ok = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:   state_next = ST_COMMIT_A;
            ST_COMMIT_A: state_next = ST_COMMIT_B;
            ST_COMMIT_B: state_next = ST_DONE;
            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            iss_cnt_reg     <= '0;
            ev_valid_reg    <= 1'b0;
            reuse_found_reg <= 1'b0;
            fresh_found_reg <= 1'b0;
            match_found_reg <= 1'b0;
            taken_reg       <= '0;
            cursor_reg      <= BASE_RESET;
            w1_en_reg       <= 1'b0;
            w2_en_reg       <= 1'b0;
            bump_reg        <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ev_valid_reg <= rd_en;
            if (start && (state_reg == ST_IDLE))
            begin
                iss_cnt_reg     <= '0;
                reuse_found_reg <= 1'b0;
                fresh_found_reg <= 1'b0;
                match_found_reg <= 1'b0;
            end
            else
            begin
                if (rd_en)
                begin
                    iss_cnt_reg <= iss_cnt_reg + CNT_W'(1);
                end
                if (hit_reuse)
                begin
                    reuse_found_reg <= 1'b1;
                end
                if (hit_fresh)
                begin
                    fresh_found_reg <= 1'b1;
                end
                if (hit_match)
                begin
                    match_found_reg <= 1'b1;
                end
            end
            if (state_reg == ST_DECIDE)
            begin
                w1_en_reg <= d_w1_en;
                w2_en_reg <= d_w2_en;
                bump_reg  <= d_bump;
            end
            if ((state_reg == ST_COMMIT_A) && w1_en_reg)
            begin
                taken_reg[w1_idx_reg] <= 1'b1;
                if (bump_reg)
                begin
                    cursor_reg <= cursor_reg + need_reg;
                end
            end
            if ((state_reg == ST_COMMIT_B) && w2_en_reg)
            begin
                taken_reg[w2_idx_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && (state_reg == ST_IDLE))
        begin
            cmd_reg      <= start_cmd;
            size_reg     <= start_size;
            addr_reg     <= start_addr;
            need_reg     <= start_need;
            size_bad_reg <= start_size_bad;
        end
        ev_idx_reg <= iss_cnt_reg[IDX_W-1:0];
        // first hit of each kind wins
        if (hit_reuse && !reuse_found_reg)
        begin
            reuse_idx_reg   <= ev_idx_reg;
            reuse_start_reg <= rd_data.start;
            reuse_span_reg  <= rd_data.span;
        end
        if (hit_fresh && !fresh_found_reg)
        begin
            fresh_idx_reg <= ev_idx_reg;
        end
        if (hit_match && !match_found_reg)
        begin
            match_idx_reg   <= ev_idx_reg;
            match_span_reg  <= rd_data.span;
            match_asked_reg <= rd_data.asked;
        end
        if (state_reg == ST_DECIDE)
        begin
            w1_idx_reg         <= d_w1_idx;
            w1_entry_reg       <= d_w1_entry;
            w2_idx_reg         <= match_idx_reg;
            w2_entry_reg       <= '{start: addr_reg, span: match_span_reg, asked: 32'd0};
            res_reg.status     <= !d_ok;
            res_reg.result_address <= d_addr;
            res_reg.copy_bytes <= d_copy;
        end
    end

    assign idle = (state_reg == ST_IDLE);
    assign done = (state_reg == ST_DONE);
    assign res  = res_reg;

    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && res_reg.status) |-> (res_reg.result_address == 32'd0)
                                     && (res_reg.copy_bytes == 32'd0))
        else $error("failed request carries an address or copy length");

    a_copy_only_realloc: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (res_reg.copy_bytes != 32'd0)) |-> (cmd_reg == CMD_REALLOC))
        else $error("copy length reported outside reallocate");

    a_cursor_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (cursor_reg != $past(cursor_reg)) |-> ($past(state_reg) == ST_COMMIT_A))
        else $error("cursor moved outside write-back");

    a_taken_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (taken_reg != $past(taken_reg)) |-> (($past(state_reg) == ST_COMMIT_A)
                                             || ($past(state_reg) == ST_COMMIT_B)))
        else $error("slot ownership changed outside write-back");

endmodule

FILE: rtl/core/page_rounded_region_allocator.sv
// Page rounded region allocator: SLOT_COUNT region slots plus a bump cursor,
// commands allocate, free and reallocate, sizes rounded up to 2^PAGE_SHIFT bytes.
// One request is handled at a time. Between acceptance and the offered result the
// engine scans the slot table, reading one slot per cycle through the single read
// port of the slot memory, and then passes the decision state and the write-back
// states COMMIT_A and COMMIT_B.
// A new request is accepted as soon as the previous result has moved into the
// output register, even while that result still waits to be taken. The slot table
// is usable straight out of reset, no clearing pass. Writing heap_base does not
// move the cursor; only reset sets it to the reset value of heap_base.
module page_rounded_region_allocator
    import prra_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]           cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            cmd,
    input  logic [31:0]           req_size,
    input  logic [31:0]           region_address,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  status,
    output logic [31:0]           result_address,
    output logic [31:0]           copy_bytes
);

    logic [31:0] heap_base_reg;
    logic [31:0] heap_top_reg;
    logic        out_valid_reg;
    result_t     out_res_reg;

    logic        eng_idle;
    logic        eng_done;
    result_t     eng_res;
    logic        res_take;

    assign cfg_ready = 1'b1;
    assign in_ready  = eng_idle;
    // result moves on whenever the output register is free or being emptied
    assign res_take  = eng_done && (!out_valid_reg || out_ready);

    prra_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (in_valid && eng_idle),
        .start_cmd  (cmd),
        .start_size (req_size),
        .start_addr (region_address),
        .idle       (eng_idle),
        .heap_base  (heap_base_reg),
        .heap_top   (heap_top_reg),
        .done       (eng_done),
        .res        (eng_res),
        .res_take   (res_take)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg <= BASE_RESET;
            heap_top_reg  <= TOP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_HEAP_BASE: heap_base_reg <= cfg_data;
                    REG_HEAP_TOP:  heap_top_reg  <= cfg_data;
                    default:       heap_top_reg  <= heap_top_reg;
                endcase
            end
            if (res_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_res_reg <= eng_res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_res_reg.status;
    assign result_address = out_res_reg.result_address;
    assign copy_bytes     = out_res_reg.copy_bytes;

endmodule

FILE: bench/page_rounded_region_allocator_tb.sv
// testbench for the page rounded region allocator: scripted and random requests against a predictor
`timescale 1ns / 1ps

module page_rounded_region_allocator_tb;
    import prra_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic RES_OK = 1'b0;
    localparam logic RES_FAIL = 1'b1;
    localparam logic PREDICT = 1'b0;
    localparam logic TYPED = 1'b1;
    localparam int DRAIN_CYCLES = SLOT_COUNT + 8;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] size;
        logic [31:0] addr;
        logic        fixed;
        result_t     want;
    } script_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] cmd = '0;
    logic [31:0] req_size = '0;
    logic [31:0] region_address = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic status;
    logic [31:0] result_address;
    logic [31:0] copy_bytes;

    // predictor copy of the slot table, cursor and heap limits
    logic        slot_busy [SLOT_COUNT];
    logic [31:0] region_at [SLOT_COUNT];
    logic [31:0] region_len [SLOT_COUNT];
    logic [31:0] region_req [SLOT_COUNT];
    logic [31:0] bump_ptr;
    logic [31:0] cfg_base;
    logic [31:0] cfg_top;

    result_t pending_results[$];
    script_row_t script_rows[$];
    int fail_count = 0;
    int sender_idle = 0;
    int recv_stall = 0;

    page_rounded_region_allocator u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .req_size       (req_size),
        .region_address (region_address),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .result_address (result_address),
        .copy_bytes     (copy_bytes)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int find_region(input logic [31:0] addr);
        int hit;
        hit = -1;
        // walk downward so the lowest matching slot wins
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
            if (slot_busy[i] && region_at[i] == addr)
                hit = i;
        return hit;
    endfunction

    function automatic bit grant_region(input logic [31:0] size, output logic [31:0] addr);
        logic [31:0] need;
        int pick;
        bit fit;
        addr = '0;
        pick = -1;
        fit = 1'b0;
        if (size == 0 || size > SIZE_LIMIT)
            return 1'b0;
        need = (size + PAGE_MASK) & ~PAGE_MASK;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (!fit && !slot_busy[i])
            begin
                if (region_at[i] != 0 && region_len[i] >= need)
                begin
                    pick = i;
                    fit = 1'b1;
                end
                else if (region_at[i] == 0 && pick < 0)
                    pick = i;
            end
        end
        if (pick < 0)
            return 1'b0;
        if (region_at[pick] == 0)
        begin
            // fresh slot: carve from the cursor
            if (bump_ptr < cfg_base || bump_ptr >= cfg_top || need > cfg_top - bump_ptr)
                return 1'b0;
            region_at[pick] = bump_ptr;
            region_len[pick] = need;
            bump_ptr = bump_ptr + need;
        end
        region_req[pick] = size;
        slot_busy[pick] = 1'b1;
        addr = region_at[pick];
        return 1'b1;
    endfunction

    function automatic bit release_region(input logic [31:0] addr);
        int k;
        if (addr == 0)
            return 1'b1;
        k = find_region(addr);
        if (k < 0)
            return 1'b0;
        region_req[k] = '0;
        slot_busy[k] = 1'b0;
        return 1'b1;
    endfunction

    function automatic result_t apply_command(input logic [1:0] op, input logic [31:0] size,
                                              input logic [31:0] addr);
        result_t r;
        bit ok;
        logic [31:0] res;
        logic [31:0] moved;
        logic [31:0] old_req;
        int k;
        ok = 1'b0;
        res = '0;
        moved = '0;
        case (op)
            CMD_ALLOC: ok = grant_region(size, res);
            CMD_FREE: ok = release_region(addr);
            CMD_REALLOC:
            begin
                if (addr == 0)
                    ok = grant_region(size, res);
                else if (size == 0)
                begin
                    void'(release_region(addr));
                    ok = 1'b1;
                end
                else
                begin
                    k = find_region(addr);
                    if (k >= 0)
                    begin
                        if (size <= region_len[k])
                        begin
                            region_req[k] = size;
                            res = addr;
                            ok = 1'b1;
                        end
                        else
                        begin
                            old_req = region_req[k];
                            if (grant_region(size, res))
                            begin
                                moved = (old_req < size) ? old_req : size;
                                void'(release_region(addr));
                                ok = 1'b1;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        if (!ok)
        begin
            res = '0;
            moved = '0;
        end
        r.status = ok ? RES_OK : RES_FAIL;
        r.result_address = res;
        r.copy_bytes = moved;
        return r;
    endfunction

    // random slot that is taken (or free but already carved), -1 if none
    function automatic int slot_pick(input logic want_busy);
        int hits[$];
        for (int i = 0; i < SLOT_COUNT; i++)
            if (slot_busy[i] == want_busy && region_at[i] != 0)
                hits.push_back(i);
        if (hits.size() == 0)
            return -1;
        return hits[$urandom_range(0, hits.size() - 1)];
    endfunction

    function automatic logic [31:0] alloc_size();
        int roll;
        int j;
        roll = $urandom_range(0, 99);
        j = slot_pick(1'b0);
        if (roll < 45 && j >= 0)
            return $urandom_range(1, region_len[j]);
        if (roll < 85)
            return $urandom_range(1, 32'h6000);
        if (roll < 93)
            return $urandom;
        if (roll < 96)
            return 32'd0;
        return SIZE_LIMIT + 32'($urandom_range(0, 1));
    endfunction

    function automatic script_row_t row(input logic [1:0] op, input logic [31:0] size,
                                        input logic [31:0] addr, input logic fixed,
                                        input logic st, input logic [31:0] ra);
        script_row_t r;
        r.op = op;
        r.size = size;
        r.addr = addr;
        r.fixed = fixed;
        r.want.status = st;
        r.want.result_address = ra;
        r.want.copy_bytes = '0;
        return r;
    endfunction

    task automatic random_request(output logic [1:0] op, output logic [31:0] size,
                                  output logic [31:0] addr);
        int roll;
        int k;
        int j;
        roll = $urandom_range(0, 99);
        k = $urandom_range(0, 9);
        size = $urandom;
        addr = $urandom;
        if (roll < 40)
        begin
            op = CMD_ALLOC;
            size = alloc_size();
        end
        else if (roll < 65)
        begin
            op = CMD_FREE;
            j = slot_pick(1'b1);
            if (k < 8 && j >= 0)
                addr = region_at[j];
            else if (k == 8)
                addr = '0;
        end
        else if (roll < 96)
        begin
            op = CMD_REALLOC;
            j = slot_pick(1'b1);
            if (k < 8 && j >= 0)
            begin
                addr = region_at[j];
                roll = $urandom_range(0, 9);
                if (roll < 3)
                    size = $urandom_range(1, region_len[j]);
                else if (roll < 7)
                    size = alloc_size();
                else if (roll < 8)
                    size = '0;
            end
            else if (k == 8)
            begin
                addr = '0;
                size = alloc_size();
            end
        end
        else
            op = CMD_UNUSED;
    endtask

    task automatic push_request(input logic [1:0] op, input logic [31:0] size,
                                input logic [31:0] addr, input logic fixed, input result_t want);
        result_t got;
        in_valid <= 1'b1;
        cmd <= op;
        req_size <= size;
        region_address <= addr;
        do @(posedge clk); while (!in_ready);
        got = apply_command(op, size, addr);
        pending_results.push_back(fixed ? want : got);
        if ($urandom_range(0, 99) < sender_idle)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < sender_idle);
        end
    endtask

    // hold off new requests until every result is back
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_e idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_HEAP_BASE)
            cfg_base = value;
        else
            cfg_top = value;
        @(posedge clk);
    endtask

    task automatic run_phase(input int count, input int snd, input int rcv);
        logic [1:0] op;
        logic [31:0] size;
        logic [31:0] addr;
        sender_idle = snd;
        recv_stall = rcv;
        repeat (count)
        begin
            random_request(op, size, addr);
            push_request(op, size, addr, PREDICT, '0);
            if ($urandom_range(0, 199) == 0)
                settle();
        end
        settle();
    endtask

    initial
    begin
        result_t want;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result status %0d address %h copy %h",
                             $time, status, result_address, copy_bytes);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (status !== want.status)
                    begin
                        $display("%0t: status expected %0d got %0d", $time, want.status, status);
                        fail_count++;
                    end
                    if (result_address !== want.result_address)
                    begin
                        $display("%0t: result_address expected %h got %h",
                                 $time, want.result_address, result_address);
                        fail_count++;
                    end
                    if (copy_bytes !== want.copy_bytes)
                    begin
                        $display("%0t: copy_bytes expected %h got %h",
                                 $time, want.copy_bytes, copy_bytes);
                        fail_count++;
                    end
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_stall);
        end
    end

    initial
    begin
        #20_000_000;
        $display("page_rounded_region_allocator test failed");
        $finish;
    end

    initial
    begin
        script_row_t r;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            slot_busy[i] = 1'b0;
            region_at[i] = '0;
            region_len[i] = '0;
            region_req[i] = '0;
        end
        bump_ptr = BASE_RESET;
        cfg_base = BASE_RESET;
        cfg_top = TOP_RESET;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        script_rows.push_back(row(CMD_ALLOC, 32'd0, 32'd0, TYPED, RES_FAIL, 32'd0));
        script_rows.push_back(row(CMD_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, TYPED, RES_FAIL, 32'd0));
        script_rows.push_back(row(CMD_ALLOC, SIZE_LIMIT + 32'd1, 32'd0, TYPED, RES_FAIL, 32'd0));
        script_rows.push_back(row(CMD_ALLOC, SIZE_LIMIT, 32'd0, PREDICT, RES_OK, 32'd0));
        // first region after reset starts at the heap base
        script_rows.push_back(row(CMD_ALLOC, 32'd1, 32'd0, TYPED, RES_OK, BASE_RESET));
        script_rows.push_back(row(CMD_ALLOC, 32'h1000, 32'd0, PREDICT, RES_OK, 32'd0));
        script_rows.push_back(row(CMD_FREE, 32'd0, 32'd0, TYPED, RES_OK, 32'd0));
        script_rows.push_back(row(CMD_FREE, 32'd0, 32'h1234_5000, TYPED, RES_FAIL, 32'd0));
        script_rows.push_back(row(CMD_FREE, 32'd0, 32'h4000_0000, PREDICT, RES_OK, 32'd0));
        // reuse of the freed slot
        script_rows.push_back(row(CMD_ALLOC, 32'h800, 32'd0, PREDICT, RES_OK, 32'd0));
        script_rows.push_back(row(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, TYPED, RES_FAIL,
                                  32'd0));
        script_rows.push_back(row(CMD_REALLOC, 32'h10, 32'd0, PREDICT, RES_OK, 32'd0));
        script_rows.push_back(row(CMD_REALLOC, 32'h1000, 32'h4000_2000, PREDICT, RES_OK, 32'd0));
        // grow past the span, region moves
        script_rows.push_back(row(CMD_REALLOC, 32'h1800, 32'h4000_2000, PREDICT, RES_OK, 32'd0));
        script_rows.push_back(row(CMD_REALLOC, 32'd0, 32'h4000_3000, PREDICT, RES_OK, 32'd0));
        script_rows.push_back(row(CMD_REALLOC, 32'd0, 32'h4000_3000, PREDICT, RES_OK, 32'd0));
        script_rows.push_back(row(CMD_REALLOC, 32'd5, 32'h5555_5000, TYPED, RES_FAIL, 32'd0));
        script_rows.push_back(row(CMD_REALLOC, 32'hFFFF_FFFF, 32'h4000_1000, TYPED, RES_FAIL,
                                  32'd0));
        script_rows.push_back(row(CMD_FREE, 32'd0, 32'h4000_1000, PREDICT, RES_OK, 32'd0));
        script_rows.push_back(row(CMD_ALLOC, 32'h2000, 32'd0, PREDICT, RES_OK, 32'd0));
        script_rows.push_back(row(CMD_REALLOC, 32'h0FFF, 32'h4000_0000, PREDICT, RES_OK, 32'd0));
        script_rows.push_back(row(CMD_FREE, 32'd0, 32'hFFFF_FFFF, TYPED, RES_FAIL, 32'd0));

        foreach (script_rows[i])
        begin
            r = script_rows[i];
            push_request(r.op, r.size, r.addr, r.fixed, r.want);
        end

        run_phase(200, 0, 0);

        // cursor below the base, nothing new can be carved
        write_reg(REG_HEAP_BASE, 32'hFFFF_FFFF);
        write_reg(REG_HEAP_TOP, 32'h0);
        run_phase(200, 0, 86);

        // cursor sits right at the top
        write_reg(REG_HEAP_BASE, 32'h0);
        write_reg(REG_HEAP_TOP, bump_ptr);
        run_phase(200, 86, 0);

        // only 64 pages (0x4_0000 bytes) of room left
        write_reg(REG_HEAP_BASE, BASE_RESET);
        write_reg(REG_HEAP_TOP, bump_ptr + 32'h4_0000);
        run_phase(250, 20, 20);

        write_reg(REG_HEAP_BASE, 32'h0);
        write_reg(REG_HEAP_TOP, 32'hFFFF_FFFF);
        run_phase(400, 0, 0);

        write_reg(REG_HEAP_BASE, BASE_RESET);
        write_reg(REG_HEAP_TOP, TOP_RESET);
        run_phase(200, 0, 86);
        run_phase(200, 20, 20);

        if (fail_count == 0)
            $display("page_rounded_region_allocator test passed");
        else
            $display("page_rounded_region_allocator test failed");
        $finish;
    end

endmodule
